/* rtl/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and codes of the control frame decoder: configuration bundle,
// result bundle, byte roles, error codes, register indexes and body phases.
// ----------------------------------------------------------------------------
package cfd_pkg;

	localparam int unsigned HDR_BYTES    = 8;
	localparam int unsigned PREFIX_BYTES = 16;
	localparam logic [7:0]  MAX_EVENT    = 8'd9;

	localparam logic [1:0] MODE_HEADER   = 2'd0;
	localparam logic [1:0] MODE_META     = 2'd1;
	localparam logic [1:0] MODE_FALLBACK = 2'd2;
	localparam logic [1:0] MODE_SPARE    = 2'd3;

	localparam int unsigned CFG_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_DECODE_MODE   = 3'd0,
		REG_MAX_LENGTH    = 3'd1,
		REG_MAGIC_VALUE   = 3'd2,
		REG_CODE_PATH     = 3'd3,
		REG_CODE_MEMFD    = 3'd4,
		REG_CODE_FALLBACK = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ROLE_HEADER = 4'd0,
		ROLE_QLEN   = 4'd1,
		ROLE_QPATH  = 4'd2,
		ROLE_BLEN   = 4'd3,
		ROLE_BPATH  = 4'd4,
		ROLE_STREAM = 4'd5,
		ROLE_STATUS = 4'd6,
		ROLE_DATA   = 4'd7,
		ROLE_EXCESS = 4'd8
	} role_t;

	typedef enum logic [3:0] {
		ERR_NONE        = 4'd0,
		ERR_TRUNC_HDR   = 4'd1,
		ERR_TRUNC_BODY  = 4'd2,
		ERR_LENGTH      = 4'd3,
		ERR_MAGIC       = 4'd4,
		ERR_VERSION     = 4'd5,
		ERR_TYPE        = 4'd6,
		ERR_WRONG_EVENT = 4'd7,
		ERR_TRAILING    = 4'd8
	} err_t;

	typedef enum logic [7:0] {
		PH_QLEN_HI  = 8'b0000_0001,
		PH_QLEN_LO  = 8'b0000_0010,
		PH_QPATH    = 8'b0000_0100,
		PH_BLEN_HI  = 8'b0000_1000,
		PH_BLEN_LO  = 8'b0001_0000,
		PH_BPATH    = 8'b0010_0000,
		PH_COMPLETE = 8'b0100_0000,
		PH_EXCESS   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0]  decode_mode;
		logic [31:0] max_length;
		logic [15:0] magic_value;
		logic [3:0]  code_path;
		logic [3:0]  code_memfd;
		logic [3:0]  code_fallback;
	} cfg_t;

	typedef struct packed {
		role_t       role;
		logic [7:0]  byte_val;
		logic        done;
		err_t        err;
		logic [31:0] frame_length;
		logic [7:0]  version;
		logic [7:0]  event_type;
		logic [31:0] stream_ident;
		logic [31:0] status_word;
		logic [7:0]  status_low;
		logic [15:0] qlen;
		logic [15:0] blen;
	} res_t;

endpackage

/* rtl/cfd_regs.sv */
// ----------------------------------------------------------------------------
// cfd_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module cfd_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cfd_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output cfd_pkg::cfg_t                   cfg
);
	import cfd_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[CFG_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decode_mode   <= MODE_HEADER;
			cfg_q.max_length    <= 32'd1048576;
			cfg_q.magic_value   <= 16'd0;
			cfg_q.code_path     <= 4'd0;
			cfg_q.code_memfd    <= 4'd5;
			cfg_q.code_fallback <= 4'd3;
		end else if (wr_en) begin
			unique case (idx)
				REG_DECODE_MODE:   cfg_q.decode_mode   <= pwdata[1:0];
				REG_MAX_LENGTH:    cfg_q.max_length    <= pwdata;
				REG_MAGIC_VALUE:   cfg_q.magic_value   <= pwdata[15:0];
				REG_CODE_PATH:     cfg_q.code_path     <= pwdata[3:0];
				REG_CODE_MEMFD:    cfg_q.code_memfd    <= pwdata[3:0];
				REG_CODE_FALLBACK: cfg_q.code_fallback <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DECODE_MODE:   prdata = {30'd0, cfg_q.decode_mode};
			REG_MAX_LENGTH:    prdata = cfg_q.max_length;
			REG_MAGIC_VALUE:   prdata = {16'd0, cfg_q.magic_value};
			REG_CODE_PATH:     prdata = {28'd0, cfg_q.code_path};
			REG_CODE_MEMFD:    prdata = {28'd0, cfg_q.code_memfd};
			REG_CODE_FALLBACK: prdata = {28'd0, cfg_q.code_fallback};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

/* rtl/cfd_decode.sv */
// ----------------------------------------------------------------------------
// cfd_decode
// Frame state and single-pass decode of one byte: field role, header and body
// capture, and the end-of-buffer error check.
// ----------------------------------------------------------------------------
module cfd_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    byte_in,
	input  logic          last_in,
	input  cfd_pkg::cfg_t cfg,
	output cfd_pkg::res_t res
);
	import cfd_pkg::*;

	logic [31:0] seen_q, len_q, ident_q, status_q;
	logic [15:0] magic_q, left_q, qlen_q, blen_q;
	logic [7:0]  ver_q, type_q;
	phase_t      phase_q;

	logic [31:0] seen_nx, len_nx, ident_nx, status_nx;
	logic [15:0] magic_nx, left_nx, qlen_nx, blen_nx, left_dec;
	logic [7:0]  ver_nx, type_nx;
	phase_t      phase_nx;
	role_t       role;
	err_t        err;
	logic        is_meta, is_fb;

	assign is_meta  = cfg.decode_mode == MODE_META;
	assign is_fb    = cfg.decode_mode == MODE_FALLBACK;
	assign left_dec = left_q - 16'd1;
	assign seen_nx  = (seen_q == '1) ? seen_q : seen_q + 32'd1;

	always_comb begin
		len_nx    = len_q;
		magic_nx  = magic_q;
		ver_nx    = ver_q;
		type_nx   = type_q;
		phase_nx  = phase_q;
		left_nx   = left_q;
		qlen_nx   = qlen_q;
		blen_nx   = blen_q;
		ident_nx  = ident_q;
		status_nx = status_q;
		role      = ROLE_HEADER;
		priority if (seen_q < 32'd4) begin
			len_nx = {len_q[23:0], byte_in};
		end else if (seen_q < 32'd6) begin
			magic_nx = {magic_q[7:0], byte_in};
		end else if (seen_q == 32'd6) begin
			ver_nx = byte_in;
		end else if (seen_q == 32'd7) begin
			type_nx = byte_in;
		end else if (is_meta) begin
			unique case (phase_q)
				PH_QLEN_HI: begin
					qlen_nx  = {byte_in, 8'd0};
					phase_nx = PH_QLEN_LO;
					role     = ROLE_QLEN;
				end
				PH_QLEN_LO: begin
					qlen_nx  = {qlen_q[15:8], byte_in};
					left_nx  = {qlen_q[15:8], byte_in};
					phase_nx = (qlen_nx != 16'd0) ? PH_QPATH : PH_BLEN_HI;
					role     = ROLE_QLEN;
				end
				PH_QPATH: begin
					left_nx  = left_dec;
					phase_nx = (left_dec == 16'd0) ? PH_BLEN_HI : PH_QPATH;
					role     = ROLE_QPATH;
				end
				PH_BLEN_HI: begin
					blen_nx  = {byte_in, 8'd0};
					phase_nx = PH_BLEN_LO;
					role     = ROLE_BLEN;
				end
				PH_BLEN_LO: begin
					blen_nx  = {blen_q[15:8], byte_in};
					left_nx  = {blen_q[15:8], byte_in};
					phase_nx = (blen_nx != 16'd0) ? PH_BPATH : PH_COMPLETE;
					role     = ROLE_BLEN;
				end
				PH_BPATH: begin
					left_nx  = left_dec;
					phase_nx = (left_dec == 16'd0) ? PH_COMPLETE : PH_BPATH;
					role     = ROLE_BPATH;
				end
				default: begin
					phase_nx = PH_EXCESS;
					role     = ROLE_EXCESS;
				end
			endcase
		end else if (is_fb) begin
			priority if (seen_q < 32'd12) begin
				ident_nx = {ident_q[23:0], byte_in};
				role     = ROLE_STREAM;
			end else if (seen_q < 32'(PREFIX_BYTES)) begin
				status_nx = {status_q[23:0], byte_in};
				role      = ROLE_STATUS;
			end else begin
				role = ROLE_DATA;
			end
		end else begin
			role = ROLE_EXCESS;
		end
	end

	// first failing check wins
	always_comb begin
		priority if (seen_nx < 32'(HDR_BYTES))
			err = ERR_TRUNC_HDR;
		else if (len_nx < 32'(HDR_BYTES) || len_nx > cfg.max_length)
			err = ERR_LENGTH;
		else if (magic_nx != cfg.magic_value)
			err = ERR_MAGIC;
		else if (ver_nx == 8'd0)
			err = ERR_VERSION;
		else if (type_nx > MAX_EVENT)
			err = ERR_TYPE;
		else if (!is_meta && !is_fb)
			err = ERR_NONE;
		else if (len_nx > seen_nx)
			err = ERR_TRUNC_BODY;
		else if (len_nx < seen_nx)
			err = ERR_TRAILING;
		else if (is_meta) begin
			priority if (type_nx != {4'd0, cfg.code_path} &&
			             type_nx != {4'd0, cfg.code_memfd})
				err = ERR_WRONG_EVENT;
			else if (phase_nx == PH_EXCESS)
				err = ERR_TRAILING;
			else if (phase_nx != PH_COMPLETE)
				err = ERR_TRUNC_BODY;
			else
				err = ERR_NONE;
		end else begin
			priority if (type_nx != {4'd0, cfg.code_fallback})
				err = ERR_WRONG_EVENT;
			else if (seen_nx < 32'(PREFIX_BYTES))
				err = ERR_TRUNC_BODY;
			else
				err = ERR_NONE;
		end
	end

	always_comb begin
		res          = '0;
		res.role     = role;
		res.byte_val = byte_in;
		res.done     = last_in;
		res.err      = last_in ? err : ERR_NONE;
		if (last_in && err == ERR_NONE) begin
			res.frame_length = len_nx;
			res.version      = ver_nx;
			res.event_type   = type_nx;
			if (is_fb) begin
				res.stream_ident = ident_nx;
				res.status_word  = status_nx;
				res.status_low   = status_nx[7:0];
			end else if (is_meta) begin
				res.qlen = qlen_nx;
				res.blen = blen_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			len_q    <= '0;
			magic_q  <= '0;
			ver_q    <= '0;
			type_q   <= '0;
			phase_q  <= PH_QLEN_HI;
			left_q   <= '0;
			qlen_q   <= '0;
			blen_q   <= '0;
			ident_q  <= '0;
			status_q <= '0;
		end else if (step) begin
			if (last_in) begin
				seen_q   <= '0;
				len_q    <= '0;
				magic_q  <= '0;
				ver_q    <= '0;
				type_q   <= '0;
				phase_q  <= PH_QLEN_HI;
				left_q   <= '0;
				qlen_q   <= '0;
				blen_q   <= '0;
				ident_q  <= '0;
				status_q <= '0;
			end else begin
				seen_q   <= seen_nx;
				len_q    <= len_nx;
				magic_q  <= magic_nx;
				ver_q    <= ver_nx;
				type_q   <= type_nx;
				phase_q  <= phase_nx;
				left_q   <= left_nx;
				qlen_q   <= qlen_nx;
				blen_q   <= blen_nx;
				ident_q  <= ident_nx;
				status_q <= status_nx;
			end
		end
	end

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_in |=> seen_q == '0 && phase_q == PH_QLEN_HI)
		else $error("frame state not cleared after final byte");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last_in && seen_q != '1 |=> seen_q == $past(seen_q) + 32'd1)
		else $error("byte count did not advance");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(seen_q) && $stable(phase_q))
		else $error("frame state moved without a request");

endmodule

/* rtl/control_frame_decoder.sv */
// ----------------------------------------------------------------------------
// control_frame_decoder
// Byte-serial control frame decoder with header and body checks.
// ----------------------------------------------------------------------------
// One request is one frame byte and produces one result, moved from the input
// register into the result register when the output is not stalled. A new
// byte can be taken on every clock while out_stall is low, so throughput is
// one byte per cycle unless the output stalls. The frame state (byte count,
// header fields, body phase) updates in a single pass between the input
// register and the result register. Mark the last byte of each buffer with
// end_of_buffer; that result carries frame_done, the error code and, with no
// error, the decoded fields; the decoder is then ready for the next buffer.
// Write the configuration registers only while no frame is in flight.
module control_frame_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           end_of_buffer,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [3:0]                     byte_role,
	output logic [7:0]                     byte_out,
	output logic                           frame_done,
	output logic [3:0]                     error_code,
	output logic [31:0]                    frame_length,
	output logic [7:0]                     proto_version,
	output logic [7:0]                     event_type,
	output logic [31:0]                    stream_ident,
	output logic [31:0]                    status_word,
	output logic [7:0]                     status_low,
	output logic [15:0]                    queue_path_length,
	output logic [15:0]                    buffer_path_length,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cfd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import cfd_pkg::*;

	cfg_t       cfg;
	res_t       res;
	res_t       res_s2;
	logic       valid_s1, valid_s2;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       load_s1, load_s2, step;

	assign load_s2  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && load_s2;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = valid_s1 && !load_s2;

	cfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cfd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= in_valid;
			if (load_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= end_of_buffer;
		end
		if (step)
			res_s2 <= res;
	end

	assign out_valid          = valid_s2;
	assign byte_role          = res_s2.role;
	assign byte_out           = res_s2.byte_val;
	assign frame_done         = res_s2.done;
	assign error_code         = res_s2.err;
	assign frame_length       = res_s2.frame_length;
	assign proto_version      = res_s2.version;
	assign event_type         = res_s2.event_type;
	assign stream_ident       = res_s2.stream_ident;
	assign status_word        = res_s2.status_word;
	assign status_low         = res_s2.status_low;
	assign queue_path_length  = res_s2.qlen;
	assign buffer_path_length = res_s2.blen;

endmodule
